FILE: rtl/g2e_pkg.sv
`default_nettype none

package g2e_pkg;

  // Default fixed-point formats of the stream fields.
  localparam int ANGLE_FRAC_BITS_DEF  = 29;
  localparam int LENGTH_FRAC_BITS_DEF = 8;

  // Field widths.
  localparam int LAT_W = 31;
  localparam int LON_W = 32;
  localparam int HGT_W = 26;
  localparam int OUT_W = 32;

  // Width of a length in Q8 with headroom for the largest height scaling.
  localparam int LEN_W = 35;

  // Angle constants in Q30 radians.
  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
  localparam logic [32:0] PI_Q30      = 33'd3373259426;
  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  // Values of [0, 2*pi) above pi/2 and below this fold back through pi.
  localparam logic [32:0] FOLD_LIMIT  = 33'd5059889139;

  localparam logic [31:0] CORDIC_GAIN  = 32'h26DD3B6A;
  localparam int          CORDIC_STEPS = 31;

  // Ellipsoid: squared eccentricity in Q40, semi-major axis in metres.
  localparam logic [32:0] E2_Q40  = 33'd7360548640;
  localparam logic [22:0] WGS84_A = 23'd6378137;

  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 31;

  localparam logic signed [36:0] OUT_LIMIT = 37'sd1700000000;

  // Truncated arctangent of 2^-i in Q30.
  function automatic logic [31:0] cordic_atan(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/g2e_delay.sv
`default_nettype none

// Shift line of DEPTH registers that advances the payload only while en is high.
module g2e_delay import g2e_pkg::*; #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] d,
  output logic      [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

`default_nettype wire

FILE: rtl/g2e_sincos.sv
`default_nettype none

// Pipelined sine and cosine: modulo reduction, quadrant fold, CORDIC, clamp.
module g2e_sincos import g2e_pkg::*; #(
  parameter int IN_W      = 32,
  parameter int SHIFT     = 1,
  parameter int MOD_STEPS = 2
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic signed [IN_W-1:0] ang,
  output logic signed [31:0]          sin_o,
  output logic signed [31:0]          cos_o
);

  localparam int MW = 33 + MOD_STEPS;
  localparam logic signed [33:0] UNIT = 34'sd1073741824;

  logic [IN_W-1:0] ang_abs;
  logic [MW-1:0]   mag [0:MOD_STEPS];
  logic            neg [0:MOD_STEPS];
  logic [32:0]     r1;
  logic            r1_neg_unused;
  logic signed [33:0] cx [1:CORDIC_STEPS];
  logic signed [33:0] cy [1:CORDIC_STEPS];
  logic signed [33:0] cz [0:CORDIC_STEPS];
  logic               cf [0:CORDIC_STEPS];

  assign ang_abs = ang[IN_W-1] ? IN_W'(-ang) : IN_W'(ang);

  always_ff @(posedge clk) begin
    if (en) begin
      mag[0] <= MW'(ang_abs) << SHIFT;
      neg[0] <= ang[IN_W-1];
    end
  end

  // One conditional subtraction of 2*pi*2^k per stage, largest first.
  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    localparam logic [MW-1:0] SUB = MW'(TWO_PI_Q30) << (MOD_STEPS - 1 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        mag[j+1] <= (mag[j] >= SUB) ? mag[j] - SUB : mag[j];
        neg[j+1] <= neg[j];
      end
    end
  end

  // Negative angles take the floor modulo, landing in [0, 2*pi).
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg[MOD_STEPS] && (mag[MOD_STEPS][32:0] != 33'd0)) begin
        r1 <= TWO_PI_Q30 - mag[MOD_STEPS][32:0];
      end else begin
        r1 <= mag[MOD_STEPS][32:0];
      end
    end
  end

  assign r1_neg_unused = 1'b0;

  // Fold into [-pi/2, pi/2]; angles that fold back through pi negate cosine.
  always_ff @(posedge clk) begin
    if (en) begin
      priority if (r1 <= HALF_PI_Q30) begin
        cz[0] <= $signed({1'b0, r1});
        cf[0] <= r1_neg_unused;
      end else if (r1 < FOLD_LIMIT) begin
        cz[0] <= $signed(34'(PI_Q30) - 34'(r1));
        cf[0] <= 1'b1;
      end else begin
        cz[0] <= $signed(34'(r1) - 34'(TWO_PI_Q30));
        cf[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [33:0] ATAN = $signed({2'b00, cordic_atan(i)});
    logic signed [33:0] xi, yi;
    if (i == 0) begin : g_first
      assign xi = $signed({2'b00, CORDIC_GAIN});
      assign yi = 34'sd0;
    end else begin : g_next
      assign xi = cx[i];
      assign yi = cy[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz[i][33]) begin
          cx[i+1] <= xi - (yi >>> i);
          cy[i+1] <= yi + (xi >>> i);
          cz[i+1] <= cz[i] - ATAN;
        end else begin
          cx[i+1] <= xi + (yi >>> i);
          cy[i+1] <= yi - (xi >>> i);
          cz[i+1] <= cz[i] + ATAN;
        end
        cf[i+1] <= cf[i];
      end
    end
  end

  logic signed [33:0] xc, yc;

  always_comb begin
    priority if (cx[CORDIC_STEPS] > UNIT) xc = UNIT;
    else if (cx[CORDIC_STEPS] < -UNIT)    xc = -UNIT;
    else                                  xc = cx[CORDIC_STEPS];
    priority if (cy[CORDIC_STEPS] > UNIT) yc = UNIT;
    else if (cy[CORDIC_STEPS] < -UNIT)    yc = -UNIT;
    else                                  yc = cy[CORDIC_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_o <= 32'(yc);
      cos_o <= cf[CORDIC_STEPS] ? 32'(-xc) : 32'(xc);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/geodetic_to_ecef_core.sv
// Throughput: one request per cycle while the output skid register is empty;
// every stage is a register and nothing iterates.
// The two CORDIC chains, the 31-stage square root and the 31-stage divider set the depth.
// Reset (rst, synchronous, active high) clears the valid bits and the output buffer;
// payload registers are not reset.
`default_nettype none

module geodetic_to_ecef_core import g2e_pkg::*; #(
  parameter int ANGLE_FRAC_BITS  = ANGLE_FRAC_BITS_DEF,
  parameter int LENGTH_FRAC_BITS = LENGTH_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // latitude [30:0], longitude [62:31], height [88:63], zero [95:89]
  input  wire logic [95:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // ecef_x [31:0], ecef_y [63:32], ecef_z [95:64]
  output logic [95:0]      m_tdata
);

  // Number of 2*pi subtraction stages needed to reduce the largest angle.
  localparam int MOD_STEPS = 31 - ANGLE_FRAC_BITS;
  localparam int ANG_SH    = 30 - ANGLE_FRAC_BITS;
  localparam int LEN_SH    = 8 - LENGTH_FRAC_BITS;
  // Stage at which the sine and cosine leave their units.
  localparam int SC_STAGE  = MOD_STEPS + 36;
  localparam int LAT       = SC_STAGE + 74;
  localparam logic signed [36:0] OUT_RND = 37'sd1 <<< LEN_SH >>> 1;

  // The whole pipeline moves whenever the output skid register is free,
  // so a request is still taken while a finished result waits.
  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign s_tready = en;

  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // Input stage: unpack and bring the height to Q8.
  logic signed [LAT_W-1:0] lat_r;
  logic signed [LON_W-1:0] lon_r;
  logic signed [LEN_W-1:0] h8_r;
  logic signed [LEN_W-1:0] h_ext;

  assign h_ext = {{(LEN_W-HGT_W){s_tdata[88]}}, s_tdata[88:63]};

  always_ff @(posedge clk) begin
    if (en) begin
      lat_r <= $signed(s_tdata[30:0]);
      lon_r <= $signed(s_tdata[62:31]);
      h8_r  <= h_ext <<< LEN_SH;
    end
  end

  logic signed [31:0] slat, clat, slon, clon;

  g2e_sincos #(.IN_W(LAT_W), .SHIFT(ANG_SH), .MOD_STEPS(MOD_STEPS)) u_sc_lat (
    .clk(clk), .en(en), .ang(lat_r), .sin_o(slat), .cos_o(clat)
  );

  g2e_sincos #(.IN_W(LON_W), .SHIFT(ANG_SH), .MOD_STEPS(MOD_STEPS)) u_sc_lon (
    .clk(clk), .en(en), .ang(lon_r), .sin_o(slon), .cos_o(clon)
  );

  // Alignment of the trigonometric terms and the height with the radius.
  logic [31:0]  clat_d;
  logic [95:0]  sc_d;
  logic [LEN_W-1:0] h8_d;

  g2e_delay #(.WIDTH(32), .DEPTH(69)) u_dl_clat (
    .clk(clk), .en(en), .d(clat), .q(clat_d)
  );

  g2e_delay #(.WIDTH(96), .DEPTH(71)) u_dl_sc (
    .clk(clk), .en(en), .d({slat, slon, clon}), .q(sc_d)
  );

  g2e_delay #(.WIDTH(LEN_W), .DEPTH(SC_STAGE + 67)) u_dl_h (
    .clk(clk), .en(en), .d(h8_r), .q(h8_d)
  );

  // sin^2 lat in Q30, e^2 sin^2 lat and w = 1 - e^2 sin^2 lat in Q40.
  logic signed [63:0] s2_full;
  logic [60:0] s2p;
  logic [30:0] s2;
  logic [63:0] tp;
  logic [40:0] w;
  logic [63:0] tp_rnd;

  assign s2_full = slat * slat;
  assign tp_rnd  = tp + (64'd1 << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      s2p <= s2_full[60:0];
      s2  <= 31'((s2p + (61'd1 << 29)) >> 30);
      tp  <= 64'(s2) * 64'(E2_Q40);
      w   <= (41'd1 << 40) - 41'(tp_rnd >> 30);
    end
  end

  // Square root of w * 2^20, one result bit per stage.
  logic [61:0] sq_rem [0:SQRT_STEPS];
  logic [61:0] sq_res [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0] <= {1'b0, w, 20'd0};
      sq_res[0] <= '0;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'd1 << (2 * (SQRT_STEPS - 1 - j));
    logic [61:0] trial;
    assign trial = sq_res[j] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_rem[j] >= trial) begin
          sq_rem[j+1] <= sq_rem[j] - trial;
          sq_res[j+1] <= (sq_res[j] >> 1) + BIT;
        end else begin
          sq_rem[j+1] <= sq_rem[j];
          sq_res[j+1] <= sq_res[j] >> 1;
        end
      end
    end
  end

  // N = round(a * 2^38 / r), restoring division, one quotient bit per stage.
  logic [30:0] root;
  logic [61:0] dv_rem [0:DIV_STEPS];
  logic [30:0] dv_div [0:DIV_STEPS];
  logic [30:0] dv_quo [0:DIV_STEPS];

  assign root = sq_res[SQRT_STEPS][30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0] <= (62'(WGS84_A) << 38) + 62'(root >> 1);
      dv_div[0] <= root;
      dv_quo[0] <= '0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int B = DIV_STEPS - 1 - k;
    logic [61:0] sub;
    assign sub = 62'(dv_div[k]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        dv_div[k+1] <= dv_div[k];
        if (dv_rem[k] >= sub) begin
          dv_rem[k+1]    <= dv_rem[k] - sub;
          dv_quo[k+1]    <= dv_quo[k] | (31'd1 << B);
        end else begin
          dv_rem[k+1]    <= dv_rem[k];
          dv_quo[k+1]    <= dv_quo[k];
        end
      end
    end
  end

  // Radius terms and the products towards x, y and z. Products round half
  // away from zero: adding half and one less for negatives before the shift.
  logic [30:0] n8, n8_1, nb;
  logic [63:0] n8e;
  logic signed [LEN_W-1:0] nh, nbh, h8_a, h8_b;
  logic signed [66:0] p1, p1_adj;
  logic signed [35:0] p;
  logic signed [67:0] px, py, px_adj, py_adj;
  logic signed [66:0] pz, pz_adj;
  logic signed [35:0] x8, y8, z8;
  logic signed [31:0] slat_d, slon_d, clon_d;
  logic [63:0] n8e_rnd;

  assign n8 = dv_quo[DIV_STEPS];
  assign {slat_d, slon_d, clon_d} = sc_d;
  assign n8e_rnd = n8e + (64'd1 << 39);

  assign p1_adj = p1 + (67'sd1 <<< 29) - $signed({66'd0, p1[66]});
  assign px_adj = px + (68'sd1 <<< 29) - $signed({67'd0, px[67]});
  assign py_adj = py + (68'sd1 <<< 29) - $signed({67'd0, py[67]});
  assign pz_adj = pz + (67'sd1 <<< 29) - $signed({66'd0, pz[66]});

  always_ff @(posedge clk) begin
    if (en) begin
      n8e  <= 64'(n8) * 64'(E2_Q40);
      nh   <= $signed({4'd0, n8}) + $signed(h8_d);
      n8_1 <= n8;
      h8_a <= $signed(h8_d);

      nb   <= n8_1 - 31'(n8e_rnd >> 40);
      p1   <= nh * $signed(clat_d);
      h8_b <= h8_a;

      p    <= 36'(p1_adj >>> 30);
      nbh  <= $signed({4'd0, nb}) + h8_b;

      px   <= p * clon_d;
      py   <= p * slon_d;
      pz   <= nbh * slat_d;

      x8   <= 36'(px_adj >>> 30);
      y8   <= 36'(py_adj >>> 30);
      z8   <= 36'(pz_adj >>> 30);
    end
  end

  // Bring to the output format and saturate.
  function automatic logic [31:0] finish(input logic signed [35:0] v8);
    logic signed [36:0] v;
    v = ($signed({v8[35], v8}) + OUT_RND) >>> LEN_SH;
    priority if (v > OUT_LIMIT) v = OUT_LIMIT;
    else if (v < -OUT_LIMIT)    v = -OUT_LIMIT;
    return v[31:0];
  endfunction

  logic [95:0] fin;

  always_ff @(posedge clk) begin
    if (en) begin
      fin <= {finish(z8), finish(y8), finish(x8)};
    end
  end

  // Output register with a skid stage behind it.
  logic        fin_valid;
  logic        out_free;
  logic [95:0] skid_data;

  assign fin_valid = vld[LAT-1];
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid   <= en && fin_valid;
      end
    end else if (en && fin_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      m_tdata <= skid_valid ? skid_data : fin;
    end else if (en && fin_valid) begin
      skid_data <= fin;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/geodetic_to_ecef_checker.sv
module geodetic_to_ecef_checker import g2e_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [95:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [95:0] m_tdata,
  output int               fail_count,
  output int               pending,
  output int               results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OUT_W-1:0] z;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] x;
  } ecef_t;

  ecef_t ecef_queue[$];

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // Product rounded half away from zero, worked on magnitudes at 128 bits.
  function automatic longint round_mul(longint a, longint b, int sh);
    logic [127:0] ua, ub, pr;
    logic neg;
    longint mag;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    pr = ua * ub + (128'd1 << (sh - 1));
    pr = pr >> sh;
    mag = longint'({1'b0, pr[62:0]});
    return neg ? -mag : mag;
  endfunction

  function automatic longint clamp_one(longint v);
    if (v > (64'sd1 <<< 30)) return 64'sd1 <<< 30;
    if (v < -(64'sd1 <<< 30)) return -(64'sd1 <<< 30);
    return v;
  endfunction

  task automatic cordic_sincos(input longint ang, output longint s, output longint c);
    longint r, x, y, nx;
    logic flip;
    r = ang % longint'(TWO_PI_Q30);
    if (r < 0) r += longint'(TWO_PI_Q30);
    if (r > longint'(PI_Q30)) r -= longint'(TWO_PI_Q30);
    flip = 1'b0;
    if (r > longint'(HALF_PI_Q30)) begin
      r = longint'(PI_Q30) - r;
      flip = 1'b1;
    end else if (r < -longint'(HALF_PI_Q30)) begin
      r = -longint'(PI_Q30) - r;
      flip = 1'b1;
    end
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (r >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        r -= longint'(cordic_atan(i));
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        r += longint'(cordic_atan(i));
      end
      x = nx;
    end
    x = clamp_one(x);
    s = clamp_one(y);
    c = flip ? -x : x;
  endtask

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] to_output(longint v);
    if (v > longint'(OUT_LIMIT)) v = longint'(OUT_LIMIT);
    if (v < -longint'(OUT_LIMIT)) v = -longint'(OUT_LIMIT);
    return v[31:0];
  endfunction

  task automatic predict_ecef(input logic [95:0] d);
    longint lat, lon, h8, slat, clat, slon, clon, s2, w, n8, nb, p;
    logic [63:0] r;
    ecef_t e;
    lat = longint'($signed(d[30:0])) * 2;
    lon = longint'($signed(d[62:31])) * 2;
    h8 = longint'($signed(d[88:63]));
    cordic_sincos(lat, slat, clat);
    cordic_sincos(lon, slon, clon);
    s2 = round_mul(slat, slat, 30);
    w = (64'sd1 <<< 40) - round_mul(longint'(E2_Q40), s2, 30);
    r = int_sqrt(64'(w) << 20);
    n8 = longint'(((64'(WGS84_A) << 38) + (r >> 1)) / r);
    nb = n8 - round_mul(n8, longint'(E2_Q40), 40);
    p = round_mul(n8 + h8, clat, 30);
    e.x = to_output(round_mul(p, clon, 30));
    e.y = to_output(round_mul(p, slon, 30));
    e.z = to_output(round_mul(nb + h8, slat, 30));
    ecef_queue.push_back(e);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %0s: got %0d expected %0d at %0t", what, $signed(got),
             $signed(want), $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    results_seen = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    ecef_t got, want;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_ecef(s_tdata);
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        results_seen++;
        if (ecef_queue.size() == 0) begin
          report_mismatch("unexpected result", got.x, 0);
        end else begin
          want = ecef_queue.pop_front();
          if (got.x !== want.x) report_mismatch("ecef_x", got.x, want.x);
          if (got.y !== want.y) report_mismatch("ecef_y", got.y, want.y);
          if (got.z !== want.z) report_mismatch("ecef_z", got.z, want.z);
        end
      end
    end
    pending = ecef_queue.size();
  end
endmodule

FILE: tb/sv/geodetic_to_ecef_core_tb.sv
module geodetic_to_ecef_core_tb;
  import g2e_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 630;
  localparam int DRAIN_CYCLES    = 150;
  localparam int LAT_MAX = 843314857;
  localparam int LON_MAX = 1686629714;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [95:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [95:0] m_tdata;
  int fail_count, pending, results_seen;
  // Idling is switched off during a quiet stretch in the middle of the run.
  logic quiet = 1'b0;

  always #1 clk = ~clk;

  geodetic_to_ecef_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  geodetic_to_ecef_checker u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  // Outside the quiet stretch, the receiver stalls at random about 27 percent of the time.
  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 27);
  end

  // Presents one request, holding tvalid through any back-pressure. Outside the
  // quiet stretch, a random idle gap with valid low may be inserted beforehand.
  task automatic send_request(input logic [30:0] lat, input logic [31:0] lon,
                              input logic [25:0] hgt);
    while (!quiet && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, hgt, lon, lat};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [25:0] random_height();
    case ($urandom_range(3))
      0: return 26'($urandom_range(512000) - 256000);
      1: return 26'($urandom_range(2560000));
      2: return 26'($urandom_range(25600000));
      default: return 26'($urandom());
    endcase
  endfunction

  initial begin
    int lat, lon;
    int drain;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Corners: poles, equator, the date line, extreme heights, and whole
    // bit patterns that exercise the range reduction and saturation.
    send_request(31'd0, 32'd0, 26'd0);
    send_request(31'(LAT_MAX), 32'd0, 26'd0);
    send_request(31'(-LAT_MAX), 32'd0, 26'd0);
    send_request(31'd0, 32'(LON_MAX), 26'd0);
    send_request(31'd0, 32'(-LON_MAX), 26'd0);
    send_request(31'd0, 32'(LON_MAX / 2), 26'd25600000);
    send_request(31'(LAT_MAX / 2), 32'(-LON_MAX / 3), 26'(-256000));
    send_request(31'h3FFFFFFF, 32'h7FFFFFFF, 26'h1FFFFFF);
    send_request(31'h40000000, 32'h80000000, 26'h2000000);
    send_request(31'h7FFFFFFF, 32'hFFFFFFFF, 26'h3FFFFFF);
    send_request(31'h00000001, 32'h00000001, 26'h0000001);
    send_request(31'h2AAAAAAA, 32'h55555555, 26'h2AAAAAA);
    send_request(31'h55555555, 32'hAAAAAAAA, 26'h1555555);
    // Latitude beyond a right angle, where cos lat turns negative.
    send_request(31'h3C000000, 32'(LON_MAX / 4), 26'd25600000);
    send_request(31'(-LAT_MAX), 32'(LON_MAX), 26'h1FFFFFF);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      quiet <= (i >= 250 && i < 350);
      if ($urandom_range(9) == 0) begin
        send_request(31'($urandom()), $urandom(), 26'($urandom()));
      end else begin
        lat = $urandom_range(2 * LAT_MAX) - LAT_MAX;
        lon = int'($urandom_range(32'(LON_MAX)) ) * ($urandom_range(1) ? 1 : -1);
        send_request(31'(lat), 32'(lon), random_height());
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge clk);

    $display("Covered %0d requests: poles, date line, height extremes and full bit patterns,",
             results_seen);
    $display("with random back-pressure on both channels and a stretch without idling.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
